[src/kls_pkg.sv]
// Shared types, token kind codes and keyword tables for the keyword lexer.
`default_nettype none
package kls_pkg;

  localparam int NUM_KW     = 12;
  localparam int KW_MAX_LEN = 8;   // table row width, longest keyword is six
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_of_source;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [7:0]  token_length;
    logic        last_of_run;
  } out_beat_t;

  // Up to two tokens handed from the scanner to the token queue in one cycle.
  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_beat_t tok0;
    out_beat_t tok1;
  } tok_push_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_STRING = 2'd3
  } mode_t;

  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_STRING  = 5'd2;
  localparam logic [4:0] KIND_KW0     = 5'd3;
  localparam logic [4:0] KIND_EQUAL   = 5'd15;
  localparam logic [4:0] KIND_LPAREN  = 5'd16;
  localparam logic [4:0] KIND_RPAREN  = 5'd17;
  localparam logic [4:0] KIND_SEMI    = 5'd18;
  localparam logic [4:0] KIND_PLUS    = 5'd19;
  localparam logic [4:0] KIND_MINUS   = 5'd20;
  localparam logic [4:0] KIND_STAR    = 5'd21;
  localparam logic [4:0] KIND_UNKNOWN = 5'd22;

  localparam logic [NUM_KW-1:0] ALL_KW = '1;

  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Keyword text, one row per keyword, zero padded.
  localparam logic [7:0] KW_CHAR [NUM_KW][KW_MAX_LEN] = '{
    '{"l", "e", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"p", "r", "i", "n", "t", 8'h0, 8'h0, 8'h0},
    '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"i", "s", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"t", "h", "a", "n", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"m", "o", "r", "e", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"l", "e", "s", "s", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"s", "t", "a", "r", "t", "s", 8'h0, 8'h0},
    '{"f", "o", "r", "m", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"t", "o", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd6, 3'd4, 3'd2
  };

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      "=":     k = KIND_EQUAL;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ";":     k = KIND_SEMI;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[src/keyword_lexer_stream.sv]
// Top level of the byte-serial keyword lexer.
// keyword_lexer_stream takes one source byte a beat and emits tokens: kind,
// start offset and length, with last_of_run set on the last token a byte
// causes. A byte lands in an input register; once the queue has room, the
// scanner classifies it against the open token (identifier, number or string),
// updates the twelve keyword match flags in parallel and writes zero, one or
// two tokens into a four-entry token queue that drives the output beat.
// Sustained rate is one byte per cycle while each byte yields at most one
// token and the output side keeps up; the queue hands out one token a beat,
// so a byte that closes a token and also makes one leaves a second token
// waiting. Each byte's tokens pass the input register and the token queue.
// in_stall rises only when the input register holds a byte and the queue
// lacks room for two tokens. end_of_source flushes any open token and
// restarts the offset count at zero. Lengths saturate at MAX_TOKEN_LENGTH
// internally and are reported capped at 255; offsets wrap at OFFSET_BITS and
// are reported as their low 16 bits.
`default_nettype none
module keyword_lexer_stream #(
  parameter int MAX_TOKEN_LENGTH = 255,
  parameter int OFFSET_BITS      = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire kls_pkg::in_beat_t  in_beat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output kls_pkg::out_beat_t      out_beat
);

  // input register
  logic               in_vld_r, in_vld_nxt;
  kls_pkg::in_beat_t  in_beat_r;
  logic               room;
  logic               go;
  logic               load;
  kls_pkg::tok_push_t push;

  // the held byte is processed when the queue can absorb two tokens
  assign go       = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign load     = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = load || (in_vld_r && !go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // payload only moves on a beat
  always_ff @(posedge clk) begin
    if (load) in_beat_r <= in_beat;
  end

  kls_scan #(
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .beat  (in_beat_r),
    .push  (push)
  );

  kls_tokq u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

[src/kls_scan.sv]
// Scanner: token state registers and the per-byte next-state and token logic.
`default_nettype none
module kls_scan #(
  parameter int MAX_TOKEN_LENGTH = 255,
  parameter int OFFSET_BITS      = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire kls_pkg::in_beat_t beat,
  output kls_pkg::tok_push_t     push
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int OFF_W = OFFSET_BITS;

  kls_pkg::mode_t              mode_r, mode_nxt, mode_s;
  logic [OFF_W-1:0]            start_r, start_nxt, start_s;
  logic [LEN_W-1:0]            len_r, len_nxt, len_s, len_grow;
  logic [kls_pkg::NUM_KW-1:0]  cand_r, cand_nxt, cand_s;
  logic [OFF_W-1:0]            offset_r, offset_nxt;
  logic [7:0]                  b;
  logic                        eos, used, close_v, single_v, eos_v;
  kls_pkg::out_beat_t          tok_close, tok_b;

  // Keywords still matching after appending byte c at position p.
  function automatic logic [kls_pkg::NUM_KW-1:0] cand_mask(
    input logic [LEN_W-1:0] p,
    input logic [7:0]       c
  );
    logic [kls_pkg::NUM_KW-1:0] m;
    m = '0;
    for (int k = 0; k < kls_pkg::NUM_KW; k++) begin
      m[k] = (32'(p) < 32'(kls_pkg::KW_LEN[k])) &&
             (kls_pkg::KW_CHAR[k][p[2:0]] == c);
    end
    return m;
  endfunction

  function automatic logic [4:0] flush_kind(
    input kls_pkg::mode_t             m,
    input logic [kls_pkg::NUM_KW-1:0] c,
    input logic [LEN_W-1:0]           l
  );
    logic [4:0] k;
    k = kls_pkg::KIND_IDENT;
    unique case (m)
      kls_pkg::MODE_IDENT: begin
        // lowest matching keyword wins
        for (int i = kls_pkg::NUM_KW - 1; i >= 0; i--) begin
          if (c[i] && (32'(l) == 32'(kls_pkg::KW_LEN[i]))) k = kls_pkg::KIND_KW0 + 5'(i);
        end
      end
      kls_pkg::MODE_NUMBER: k = kls_pkg::KIND_NUMBER;
      kls_pkg::MODE_STRING: k = kls_pkg::KIND_STRING;
      default:              k = kls_pkg::KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] sat_len(input logic [LEN_W-1:0] l);
    return (32'(l) > 32'd255) ? 8'd255 : 8'(l);
  endfunction

  always_comb begin
    b        = beat.src_byte;
    eos      = beat.end_of_source;
    mode_s   = mode_r;
    start_s  = start_r;
    len_s    = len_r;
    cand_s   = cand_r;
    used     = 1'b0;
    close_v  = 1'b0;
    single_v = 1'b0;
    len_grow = (len_r < LEN_W'(MAX_TOKEN_LENGTH)) ? len_r + LEN_W'(1) : len_r;

    unique case (mode_r)
      kls_pkg::MODE_STRING: begin
        used = 1'b1;
        if (b == kls_pkg::CH_QUOTE) begin
          close_v = 1'b1;
          mode_s  = kls_pkg::MODE_IDLE;
        end else begin
          len_s = len_grow;
        end
      end
      kls_pkg::MODE_IDENT: begin
        if (kls_pkg::is_letter(b) || kls_pkg::is_digit(b)) begin
          used   = 1'b1;
          cand_s = cand_r & cand_mask(len_r, b);
          len_s  = len_grow;
        end else begin
          close_v = 1'b1;
          mode_s  = kls_pkg::MODE_IDLE;
        end
      end
      kls_pkg::MODE_NUMBER: begin
        if (kls_pkg::is_digit(b)) begin
          used  = 1'b1;
          len_s = len_grow;
        end else begin
          close_v = 1'b1;
          mode_s  = kls_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase

    // byte not consumed by an open token: handle as from idle
    if (!used) begin
      priority if (kls_pkg::is_blank(b)) begin
        // skipped
      end else if (kls_pkg::is_letter(b)) begin
        mode_s  = kls_pkg::MODE_IDENT;
        start_s = offset_r;
        len_s   = LEN_W'(1);
        cand_s  = cand_mask('0, b);
      end else if (kls_pkg::is_digit(b)) begin
        mode_s  = kls_pkg::MODE_NUMBER;
        start_s = offset_r;
        len_s   = LEN_W'(1);
      end else if (b == kls_pkg::CH_QUOTE) begin
        mode_s  = kls_pkg::MODE_STRING;
        start_s = offset_r + OFF_W'(1);
        len_s   = '0;
      end else begin
        single_v = 1'b1;
      end
    end

    eos_v = eos && (mode_s != kls_pkg::MODE_IDLE);

    tok_close.token_kind   = flush_kind(mode_r, cand_r, len_r);
    tok_close.start_offset = 16'(start_r);
    tok_close.token_length = sat_len(len_r);
    tok_close.last_of_run  = 1'b0;

    if (single_v) begin
      tok_b.token_kind   = kls_pkg::single_kind(b);
      tok_b.start_offset = 16'(offset_r);
      tok_b.token_length = 8'd1;
    end else begin
      tok_b.token_kind   = flush_kind(mode_s, cand_s, len_s);
      tok_b.start_offset = 16'(start_s);
      tok_b.token_length = sat_len(len_s);
    end
    tok_b.last_of_run = 1'b1;

    push.vld0 = go && (close_v || single_v || eos_v);
    push.vld1 = go && close_v && (single_v || eos_v);
    push.tok0 = close_v ? tok_close : tok_b;
    push.tok0.last_of_run = !(close_v && (single_v || eos_v));
    push.tok1 = tok_b;

    if (eos) begin
      mode_nxt   = kls_pkg::MODE_IDLE;
      start_nxt  = '0;
      len_nxt    = '0;
      cand_nxt   = kls_pkg::ALL_KW;
      offset_nxt = '0;
    end else begin
      mode_nxt   = mode_s;
      start_nxt  = start_s;
      len_nxt    = len_s;
      cand_nxt   = cand_s;
      offset_nxt = offset_r + OFF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= kls_pkg::MODE_IDLE;
      start_r  <= '0;
      len_r    <= '0;
      cand_r   <= kls_pkg::ALL_KW;
      offset_r <= '0;
    end else if (go) begin
      mode_r   <= mode_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      cand_r   <= cand_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule
`default_nettype wire

[src/kls_tokq.sv]
// Token queue: takes up to two tokens a cycle, hands out one token a beat.
`default_nettype none
module kls_tokq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kls_pkg::tok_push_t push,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output kls_pkg::out_beat_t      out_beat
);

  kls_pkg::out_beat_t            mem_r [kls_pkg::FIFO_DEPTH];
  logic [kls_pkg::FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [kls_pkg::FIFO_CW-1:0]   count_r, count_nxt;
  logic [kls_pkg::FIFO_CW-1:0]   n_push;
  logic                          pop;

  always_comb begin
    pop        = out_valid && !out_stall;
    n_push     = kls_pkg::FIFO_CW'(push.vld0) + kls_pkg::FIFO_CW'(push.vld1);
    wr_ptr_nxt = wr_ptr_r + kls_pkg::FIFO_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + kls_pkg::FIFO_AW'(pop);
    count_nxt  = count_r + n_push - kls_pkg::FIFO_CW'(pop);
  end

  // space for a full two-token burst
  assign room      = (32'(count_r) <= kls_pkg::FIFO_DEPTH - 2);
  assign out_valid = (count_r != '0);
  assign out_beat  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld0) mem_r[wr_ptr_r] <= push.tok0;
    if (push.vld1) mem_r[wr_ptr_r + kls_pkg::FIFO_AW'(1)] <= push.tok1;
  end

endmodule
`default_nettype wire

[src/kls_checker.sv]
// Port-level checker for the keyword lexer, bound to the top level.
`default_nettype none
module kls_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire kls_pkg::in_beat_t in_beat,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire kls_pkg::out_beat_t out_beat
);

  // a stalled token holds its place and value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("stalled output beat changed");

  // a stalled input beat is held by the source
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_beat))
    else $error("stalled input beat changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // operator and unknown tokens are one byte long
  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.token_kind >= kls_pkg::KIND_EQUAL) |->
      out_beat.token_length == 8'd1)
    else $error("single-byte token with wrong length");

  // only a string token can be empty, and kinds stay in range
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.token_kind != kls_pkg::KIND_STRING) |->
      (out_beat.token_length != 8'd0) &&
      (out_beat.token_kind <= kls_pkg::KIND_UNKNOWN))
    else $error("empty non-string token or bad kind");

endmodule

bind keyword_lexer_stream kls_checker u_kls_checker (.*);
`default_nettype wire

[tb/kls_token_checker.sv]
// Token checker for the keyword lexer: predicts tokens from accepted bytes, compares out beats.
module kls_token_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  kls_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  logic               out_stall,
  input  kls_pkg::out_beat_t out_beat,
  output int                 fail_count,
  output int                 tokens_pending,
  output int                 tokens_checked
);

  localparam int MAX_LEN = 255;

  string kw_words [12] = '{"let", "print", "if", "is", "than", "more",
                           "less", "else", "for", "starts", "form", "to"};

  // predicted scanner state
  kls_pkg::mode_t scan      = kls_pkg::MODE_IDLE;
  logic [15:0]    tok_start = '0;
  logic [7:0]     tok_len   = '0;
  logic [11:0]    kw_live   = '1;
  logic [15:0]    next_off  = '0;

  kls_pkg::out_beat_t tokens_due [$];
  int                 mismatches = 0;
  int                 checked    = 0;

  function automatic bit is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0d]};
  endfunction

  function automatic logic [4:0] op_kind(logic [7:0] c);
    unique case (c)
      "=":     return kls_pkg::KIND_EQUAL;
      "(":     return kls_pkg::KIND_LPAREN;
      ")":     return kls_pkg::KIND_RPAREN;
      ";":     return kls_pkg::KIND_SEMI;
      "+":     return kls_pkg::KIND_PLUS;
      "-":     return kls_pkg::KIND_MINUS;
      "*":     return kls_pkg::KIND_STAR;
      default: return kls_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  task automatic lengthen();
    if (tok_len < MAX_LEN) tok_len++;
  endtask

  // drop every keyword whose next character differs
  task automatic match_letter(logic [7:0] c);
    int p;
    p = int'(tok_len);
    for (int k = 0; k < 12; k++) begin
      if (p >= kw_words[k].len() || kw_words[k][p] != c) kw_live[k] = 1'b0;
    end
    lengthen();
  endtask

  function automatic bit close_token(output kls_pkg::out_beat_t t);
    logic [4:0] kind;
    bit         found;
    t = '0;
    kind = kls_pkg::KIND_IDENT;
    found = 1'b0;
    unique case (scan)
      kls_pkg::MODE_IDLE:   return 1'b0;
      kls_pkg::MODE_NUMBER: kind = kls_pkg::KIND_NUMBER;
      kls_pkg::MODE_STRING: kind = kls_pkg::KIND_STRING;
      default: begin
        for (int k = 0; k < 12; k++) begin
          if (!found && kw_live[k] && tok_len == kw_words[k].len()) begin
            kind = 5'(kls_pkg::KIND_KW0 + k);
            found = 1'b1;
          end
        end
      end
    endcase
    t = '{kind, tok_start, tok_len, 1'b0};
    scan = kls_pkg::MODE_IDLE;
    return 1'b1;
  endfunction

  task automatic lex_byte(input kls_pkg::in_beat_t ib);
    kls_pkg::out_beat_t made [2];
    kls_pkg::out_beat_t t;
    int                 n;
    bit                 taken;
    logic [7:0]         c;
    logic [15:0]        here;
    n = 0;
    taken = 1'b0;
    c = ib.src_byte;
    here = next_off;
    // open token first; a byte that closes an identifier or number falls through to the idle handling
    unique case (scan)
      kls_pkg::MODE_STRING: begin
        if (c == kls_pkg::CH_QUOTE) begin
          if (close_token(t)) begin
            made[n] = t;
            n++;
          end
        end else begin
          lengthen();
        end
        taken = 1'b1;
      end
      kls_pkg::MODE_IDENT: begin
        if (is_alpha(c) || is_num(c)) begin
          match_letter(c);
          taken = 1'b1;
        end else if (close_token(t)) begin
          made[n] = t;
          n++;
        end
      end
      kls_pkg::MODE_NUMBER: begin
        if (is_num(c)) begin
          lengthen();
          taken = 1'b1;
        end else if (close_token(t)) begin
          made[n] = t;
          n++;
        end
      end
      default: ;
    endcase
    if (!taken && !is_space(c)) begin
      if (is_alpha(c)) begin
        scan = kls_pkg::MODE_IDENT;
        tok_start = here;
        tok_len = '0;
        kw_live = '1;
        match_letter(c);
      end else if (is_num(c)) begin
        scan = kls_pkg::MODE_NUMBER;
        tok_start = here;
        tok_len = 8'd1;
      end else if (c == kls_pkg::CH_QUOTE) begin
        scan = kls_pkg::MODE_STRING;
        tok_start = here + 16'd1;
        tok_len = '0;
      end else begin
        made[n] = '{op_kind(c), here, 8'd1, 1'b0};
        n++;
      end
    end
    next_off = here + 16'd1;
    if (ib.end_of_source) begin
      if (close_token(t)) begin
        made[n] = t;
        n++;
      end
      scan = kls_pkg::MODE_IDLE;
      tok_start = '0;
      tok_len = '0;
      kw_live = '1;
      next_off = '0;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) made[i].last_of_run = 1'b1;
      tokens_due.push_back(made[i]);
    end
  endtask

  task automatic report(string what, int want, int got);
    mismatches++;
    $display("MISMATCH %s: expected %0d, got %0d (token %0d)", what, want, got, checked);
  endtask

  task automatic check_token(input kls_pkg::out_beat_t got);
    kls_pkg::out_beat_t want;
    checked++;
    if (tokens_due.size() == 0) begin
      report("token with none pending, kind", -1, int'(got.token_kind));
      return;
    end
    want = tokens_due.pop_front();
    if (got.token_kind != want.token_kind)
      report("token_kind", int'(want.token_kind), int'(got.token_kind));
    if (got.start_offset != want.start_offset)
      report("start_offset", int'(want.start_offset), int'(got.start_offset));
    if (got.token_length != want.token_length)
      report("token_length", int'(want.token_length), int'(got.token_length));
    if (got.last_of_run != want.last_of_run)
      report("last_of_run", int'(want.last_of_run), int'(got.last_of_run));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scan = kls_pkg::MODE_IDLE;
      tok_start = '0;
      tok_len = '0;
      kw_live = '1;
      next_off = '0;
      tokens_due.delete();
    end else begin
      if (in_valid && !in_stall) lex_byte(in_beat);
      if (out_valid && !out_stall) check_token(out_beat);
    end
    fail_count <= mismatches;
    tokens_pending <= tokens_due.size();
    tokens_checked <= checked;
  end

endmodule

[tb/keyword_lexer_stream_tb.sv]
// Testbench top for keyword_lexer_stream: clock, reset, byte stimulus, output stall and verdict.
module keyword_lexer_stream_tb;

  // Cycles with no beat moving on either channel before the run is called hung.
  // Output stall bursts are bounded, so this is far beyond any correct run.
  localparam int IDLE_LIMIT   = 1000;
  // Settle time after the last expected token: covers the input register and
  // token queue path plus a drained queue, so a stray extra token still gets caught.
  localparam int DRAIN_CYCLES = 8;
  // One longer source with many tokens in a row.
  localparam int LONG_BYTES   = 300;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  kls_pkg::in_beat_t  in_beat   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  kls_pkg::out_beat_t out_beat;

  int fail_count;
  int tokens_pending;
  int tokens_checked;

  // Idling knobs; the stimulus flips them per source so stretches with and
  // without gaps both occur.
  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  int stall_left  = 0;

  logic [7:0] src_text [$];   // bytes of the token being built, sent in one go
  int bytes_sent   = 0;
  int sources_sent = 0;
  int src_bytes    = 0;       // bytes sent in the current source
  int idle_run     = 0;
  int target;

  string kw_list [12] = '{"let", "print", "if", "is", "than", "more",
                          "less", "else", "for", "starts", "form", "to"};

  keyword_lexer_stream dut (.*);

  kls_token_checker u_checker (.*);

  always #5 clk = ~clk;

  // Output-side backpressure: random stall bursts.
  always @(posedge clk) begin
    if (!rst_n || !out_gaps_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any accepted beat on either side resets the count.
  initial begin
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // One byte beat. An optional gap drops valid first; valid otherwise stays
  // high across back-to-back beats, and the payload holds until the beat is
  // taken.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= '{src_byte: b, end_of_source: eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    src_bytes++;
  endtask

  // Sends the buffered bytes; with eos set the last one closes the source.
  task automatic emit_text(input bit eos);
    for (int i = 0; i < src_text.size(); i++)
      send_byte(src_text[i], eos && (i == src_text.size() - 1));
    src_text.delete();
    if (eos) begin
      sources_sent++;
      src_bytes = 0;
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    return 8'(8'h30 + r - 52);
  endfunction

  task automatic add_blanks();
    int n;
    int c;
    n = $urandom_range(1, 3);
    repeat (n) begin
      c = $urandom_range(0, 5);
      src_text.push_back((c == 5) ? 8'h20 : 8'(9 + c));
    end
  endtask

  // Appends one token-shaped piece of text. Most are well formed; a share is
  // near-miss keywords, unclosed strings and raw noise bytes.
  task automatic add_token();
    int         r;
    int         v;
    int         n;
    bit         huge;
    string      w;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    huge = ($urandom_range(0, 49) == 0);   // pushes lengths past saturation
    if (r < 25) begin
      // keyword, or a truncated, extended or recased near miss
      w = kw_list[$urandom_range(0, 11)];
      v = $urandom_range(0, 9);
      n = w.len();
      if (v == 6 || v == 7) n = (n > 1) ? n - 1 : 1;
      for (int i = 0; i < n; i++) begin
        c = w[i];
        if (v == 9 && i == 0) c = c - 8'd32;
        src_text.push_back(c);
      end
      if (v == 8) src_text.push_back(rand_alnum());
    end else if (r < 40) begin
      n = huge ? $urandom_range(250, 300) : $urandom_range(0, 7);
      c = 8'(8'h61 + $urandom_range(0, 25));
      if ($urandom_range(0, 1)) c = c - 8'd32;
      src_text.push_back(c);
      repeat (n) src_text.push_back(rand_alnum());
    end else if (r < 52) begin
      n = huge ? $urandom_range(250, 300) : $urandom_range(1, 6);
      repeat (n) src_text.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end else if (r < 62) begin
      n = huge ? $urandom_range(250, 300) : $urandom_range(0, 8);
      src_text.push_back(kls_pkg::CH_QUOTE);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        if (c == kls_pkg::CH_QUOTE) c = "q";
        src_text.push_back(c);
      end
      if ($urandom_range(0, 11) != 0) src_text.push_back(kls_pkg::CH_QUOTE);
    end else if (r < 82) begin
      w = "=();+-*";
      src_text.push_back(w[$urandom_range(0, 6)]);
    end else if (r < 90) begin
      add_blanks();
    end else begin
      src_text.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // A source of at least n_tok token pieces and min_len bytes. Its end marker lands
  // either on the last byte of the last piece or on one extra random byte.
  task automatic random_source(input int n_tok, input int min_len);
    for (int i = 0; ; i++) begin
      add_token();
      if ($urandom_range(0, 2) != 0) add_blanks();
      if (i + 1 >= n_tok && src_bytes + src_text.size() >= min_len) break;
      emit_text(1'b0);
    end
    if ($urandom_range(0, 1)) src_text.push_back(8'($urandom_range(0, 255)));
    emit_text(1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: mixed tokens, every operator, unknown bytes at both ends of
    // the byte range, an empty string, all whitespace, an unclosed string
    // flushed by end of source, and a keyword flushed by end of source.
    push_text("x1=(42);");
    emit_text(1'b1);
    push_text("+-*");
    src_text.push_back(8'h00);
    src_text.push_back(8'h80);
    src_text.push_back(8'hff);
    emit_text(1'b1);
    push_text("\"\" ");
    for (int c = 9; c <= 13; c++) src_text.push_back(8'(c));
    push_text("\"ab");
    emit_text(1'b1);
    push_text(" if");
    emit_text(1'b1);

    // Random sources; gaps toggle per source on each side independently.
    target = bytes_sent + 700;
    while (bytes_sent < target) begin
      in_gaps_on = (sources_sent % 4 != 3);
      out_gaps_on = (sources_sent % 3 != 2);
      random_source($urandom_range(1, 12), 0);
    end

    // One longer source with many tokens.
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    random_source(20, LONG_BYTES);

    target = bytes_sent + 500;
    while (bytes_sent < target) begin
      in_gaps_on = (sources_sent % 4 != 1);
      out_gaps_on = (sources_sent % 3 != 0);
      random_source($urandom_range(1, 12), 0);
    end

    // Closing stretch at full rate on both sides.
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    target = bytes_sent + 200;
    while (bytes_sent < target) random_source($urandom_range(1, 12), 0);

    in_valid <= 1'b0;
    // Let the checker's registered count take in the last byte's tokens.
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Lexed %0d bytes in %0d sources, with gaps and stalls on both sides",
             bytes_sent, sources_sent);
    $display("and a full-rate finish; %0d tokens compared, %0d mismatches.",
             tokens_checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
